FILE: rtl/mbr_pkg.sv
// shared types, widths and codes for the modular add/sub/mul unit
package mbr_pkg;

	localparam int RES_W   = 63;
	localparam int WORD_W  = 64;
	localparam int SHIFT_W = 6;
	localparam int IDX_W   = 2;

	typedef logic [1:0] op_t;

	localparam op_t OP_ADD  = 2'd0;
	localparam op_t OP_SUB  = 2'd1;
	localparam op_t OP_MUL  = 2'd2;
	localparam op_t OP_NONE = 2'd3;

	localparam logic [IDX_W-1:0] REG_MODULUS  = 2'd0;
	localparam logic [IDX_W-1:0] REG_RATIO    = 2'd1;
	localparam logic [IDX_W-1:0] REG_EXPONENT = 2'd2;

	localparam logic [RES_W-1:0]   MODULUS_RST = 63'd2;
	localparam logic [WORD_W-1:0]  RATIO_RST   = 64'h8000_0000_0000_0000;
	localparam logic [SHIFT_W-1:0] SHIFT_RST   = 6'd0;

	// live configuration seen by the datapath
	typedef struct packed {
		logic [RES_W-1:0]   modulus;
		logic [WORD_W-1:0]  ratio;
		logic [SHIFT_W-1:0] shift;
	} cfg_t;

	// sideband that travels with each transaction down the pipeline
	typedef struct packed {
		logic              valid;
		op_t               op;
		logic [WORD_W-1:0] val;
		logic              borrow;
	} side_t;

endpackage

FILE: rtl/mbr_in_if.sv
// operand channel: operation selector and two residues
interface mbr_in_if;
	logic                      valid;
	logic                      ready;
	mbr_pkg::op_t              operation;
	logic [mbr_pkg::RES_W-1:0] operand_a;
	logic [mbr_pkg::RES_W-1:0] operand_b;

	modport source (output valid, output operation, output operand_a, output operand_b,
		input ready);
	modport sink (input valid, input operation, input operand_a, input operand_b,
		output ready);
endinterface

FILE: rtl/mbr_out_if.sv
// result channel: reduced residue
interface mbr_out_if;
	logic                      valid;
	logic                      ready;
	logic [mbr_pkg::RES_W-1:0] residue;

	modport source (output valid, output residue, input ready);
	modport sink (input valid, input residue, output ready);
endinterface

FILE: rtl/mbr_cfg_if.sv
// configuration write channel: register index and write data
interface mbr_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [mbr_pkg::IDX_W-1:0]  index;
	logic [mbr_pkg::WORD_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/mbr_cfg.sv
// configuration registers: modulus, barrett ratio and product shift amount
module mbr_cfg (
	input  logic            clk,
	input  logic            arst_n,
	mbr_cfg_if.sink         cfg,
	output mbr_pkg::cfg_t   cfg_out
);
	import mbr_pkg::*;

	logic [RES_W-1:0]   modulus_q;
	logic [WORD_W-1:0]  ratio_q;
	logic [SHIFT_W-1:0] shift_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RST;
			ratio_q   <= RATIO_RST;
			shift_q   <= SHIFT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MODULUS: modulus_q <= cfg.data[RES_W-1:0];
				REG_RATIO:   ratio_q   <= cfg.data;
				// exponent zero behaves as one
				REG_EXPONENT: begin
					if (cfg.data[SHIFT_W-1:0] == '0)
						shift_q <= '0;
					else
						shift_q <= cfg.data[SHIFT_W-1:0] - SHIFT_W'(1);
				end
				default: ;
			endcase
		end
	end

	assign cfg_out.modulus = modulus_q;
	assign cfg_out.ratio   = ratio_q;
	assign cfg_out.shift   = shift_q;

endmodule

FILE: rtl/mbr_prod.sv
// stages 1-3: a*b partial products, product sum, shift by exponent-1; add/sub raw value
module mbr_prod (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  mbr_pkg::op_t                op,
	input  logic [mbr_pkg::RES_W-1:0]   a,
	input  logic [mbr_pkg::RES_W-1:0]   b,
	input  logic [mbr_pkg::SHIFT_W-1:0] shift,
	output mbr_pkg::side_t              side_s3,
	output logic [mbr_pkg::WORD_W-1:0]  shifted_s3
);
	import mbr_pkg::*;

	localparam int PROD_W = 2 * RES_W;

	side_t             side_s1, side_s2;
	logic [63:0]       pp00_s1;
	logic [62:0]       pp01_s1, pp10_s1;
	logic [61:0]       pp11_s1;
	logic [PROD_W-1:0] prod_s2;
	logic [PROD_W-1:0] prod_shr;
	logic [PROD_W-1:0] prod_sum;
	logic [WORD_W-1:0] a_ext, b_ext;

	assign a_ext = {1'b0, a};
	assign b_ext = {1'b0, b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
			side_s3 <= '0;
		end else if (en) begin
			side_s1.valid  <= in_valid;
			side_s1.op     <= op;
			side_s1.val    <= (op == OP_SUB) ? a_ext - b_ext : a_ext + b_ext;
			side_s1.borrow <= a < b;

			side_s2.valid  <= side_s1.valid;
			side_s2.op     <= side_s1.op;
			side_s2.borrow <= side_s1.borrow;
			// from here on a multiply carries the low product word
			side_s2.val    <= (side_s1.op == OP_MUL) ? prod_sum[WORD_W-1:0] : side_s1.val;

			side_s3 <= side_s2;
		end
	end

	assign prod_sum = PROD_W'(pp00_s1) + (PROD_W'(pp01_s1) << 32)
		+ (PROD_W'(pp10_s1) << 32) + (PROD_W'(pp11_s1) << 64);
	assign prod_shr = prod_s2 >> shift;

	always_ff @(posedge clk) begin
		if (en) begin
			pp00_s1    <= 64'(a[31:0]) * 64'(b[31:0]);
			pp01_s1    <= 63'(a[31:0]) * 63'(b[62:32]);
			pp10_s1    <= 63'(a[62:32]) * 63'(b[31:0]);
			pp11_s1    <= 62'(a[62:32]) * 62'(b[62:32]);
			prod_s2    <= prod_sum;
			shifted_s3 <= prod_shr[WORD_W-1:0];
		end
	end

`ifndef ASSERT_OFF
	a_s1_follows_input: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> side_s1.valid == $past(in_valid))
		else $error("stage 1 valid does not follow accepted input");
	a_prod_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(prod_s2) && $stable(side_s2))
		else $error("product stage changed while stalled");
`endif

endmodule

FILE: rtl/mbr_quot.sv
// stages 4-5: quotient estimate, high word of shifted product times ratio
module mbr_quot (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  mbr_pkg::side_t             side_in,
	input  logic [mbr_pkg::WORD_W-1:0] shifted,
	input  logic [mbr_pkg::WORD_W-1:0] ratio,
	output mbr_pkg::side_t             side_s5,
	output logic [mbr_pkg::WORD_W-1:0] qh_s5
);
	import mbr_pkg::*;

	localparam int FULL_W = 2 * WORD_W;

	side_t             side_s4;
	logic [63:0]       r00_s4, r01_s4, r10_s4, r11_s4;
	logic [FULL_W-1:0] full_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s4 <= '0;
			side_s5 <= '0;
		end else if (en) begin
			side_s4 <= side_in;
			side_s5 <= side_s4;
		end
	end

	assign full_sum = FULL_W'(r00_s4) + (FULL_W'(r01_s4) << 32)
		+ (FULL_W'(r10_s4) << 32) + (FULL_W'(r11_s4) << 64);

	always_ff @(posedge clk) begin
		if (en) begin
			r00_s4 <= 64'(shifted[31:0]) * 64'(ratio[31:0]);
			r01_s4 <= 64'(shifted[31:0]) * 64'(ratio[63:32]);
			r10_s4 <= 64'(shifted[63:32]) * 64'(ratio[31:0]);
			r11_s4 <= 64'(shifted[63:32]) * 64'(ratio[63:32]);
			qh_s5  <= full_sum[FULL_W-1:WORD_W];
		end
	end

`ifndef ASSERT_OFF
	a_quot_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(qh_s5) && $stable(side_s5))
		else $error("quotient stage changed while stalled");
`endif

endmodule

FILE: rtl/mbr_reduce.sv
// stages 6-8: q*p low word, remainder, final conditional correction
module mbr_reduce (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  mbr_pkg::side_t             side_in,
	input  logic [mbr_pkg::WORD_W-1:0] qh,
	input  logic [mbr_pkg::RES_W-1:0]  modulus,
	output logic                       valid_s8,
	output logic [mbr_pkg::RES_W-1:0]  residue_s8
);
	import mbr_pkg::*;

	side_t             side_s6, side_s7;
	logic [63:0]       m0_s6;
	logic [31:0]       m1_s6, m2_s6;
	logic [WORD_W-1:0] qp_lo;
	logic [WORD_W-1:0] mod_ext;
	logic [WORD_W-1:0] fin;

	assign mod_ext = {1'b0, modulus};
	assign qp_lo   = m0_s6 + {m1_s6 + m2_s6, 32'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s6  <= '0;
			side_s7  <= '0;
			valid_s8 <= 1'b0;
		end else if (en) begin
			side_s6        <= side_in;
			side_s7.valid  <= side_s6.valid;
			side_s7.op     <= side_s6.op;
			side_s7.borrow <= side_s6.borrow;
			side_s7.val    <= (side_s6.op == OP_MUL) ? side_s6.val - qp_lo : side_s6.val;
			valid_s8       <= side_s7.valid;
		end
	end

	always_comb begin
		case (side_s7.op)
			OP_ADD, OP_MUL: fin = (side_s7.val >= mod_ext) ? side_s7.val - mod_ext : side_s7.val;
			OP_SUB:         fin = side_s7.borrow ? side_s7.val + mod_ext : side_s7.val;
			default:        fin = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m0_s6      <= 64'(qh[31:0]) * 64'(modulus[31:0]);
			m1_s6      <= 32'(qh[31:0]) * 32'(modulus[62:32]);
			m2_s6      <= 32'(qh[63:32]) * 32'(modulus[31:0]);
			residue_s8 <= fin[RES_W-1:0];
		end
	end

`ifndef ASSERT_OFF
	a_s8_follows_s7: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> valid_s8 == $past(side_s7.valid))
		else $error("output valid does not follow stage 7");
`endif

endmodule

FILE: rtl/modular_add_sub_mul_barrett.sv
// top level of the pipelined modular add/subtract/Barrett-multiply unit
// One transaction per cycle is accepted while the pipe is not held: stages 1-3 form
// a*b from 32-bit partial products and shift it right by exponent-1, stages 4-5 take
// the high word of that value times the Barrett ratio, stages 6-8 subtract
// quotient*p and apply the final single correction (add and subtract ride the same
// pipe, form a+b or a-b in stage 1 and use only the final correction). The latency
// is set by the three chained 64-bit multiplies split into 32x32 pieces. When the
// result is not taken the whole pipe holds and operands.ready drops in the same
// cycle. Configuration is taken every cycle and must only be written while no
// transaction is in flight; index 0 is the modulus, 1 the Barrett ratio,
// 2 the exponent (0 acts as 1); unused operation code 3 yields residue 0.
module modular_add_sub_mul_barrett (
	input  logic      clk,
	input  logic      arst_n,
	mbr_in_if.sink    operands,
	mbr_out_if.source results,
	mbr_cfg_if.sink   cfg
);
	import mbr_pkg::*;

	cfg_t              cfg_live;
	logic              en;
	side_t             side_s3, side_s5;
	logic [WORD_W-1:0] shifted_s3, qh_s5;

	// pipe advances when the output register is empty or being drained
	assign en             = !results.valid || results.ready;
	assign operands.ready = en;

	mbr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_out (cfg_live)
	);

	mbr_prod u_prod (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (operands.valid),
		.op         (operands.operation),
		.a          (operands.operand_a),
		.b          (operands.operand_b),
		.shift      (cfg_live.shift),
		.side_s3    (side_s3),
		.shifted_s3 (shifted_s3)
	);

	mbr_quot u_quot (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.side_in (side_s3),
		.shifted (shifted_s3),
		.ratio   (cfg_live.ratio),
		.side_s5 (side_s5),
		.qh_s5   (qh_s5)
	);

	mbr_reduce u_reduce (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.side_in    (side_s5),
		.qh         (qh_s5),
		.modulus    (cfg_live.modulus),
		.valid_s8   (results.valid),
		.residue_s8 (results.residue)
	);

`ifndef ASSERT_OFF
	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_live.shift <= SHIFT_W'(62))
		else $error("product shift out of range");
`endif

endmodule
